@@ rtl/core/fict_pkg.sv @@
// ----------------------------------------------------------------------------
// fict_pkg
// Shared constants, types and state codes of the frequent-items counter table.
// ----------------------------------------------------------------------------
package fict_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int KEY_BITS  = 32;
  localparam int SLOT_IW   = $clog2(NUM_SLOTS);

  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int CNT_W     = 32;
  localparam int FRAC_W    = 18;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = FRAC_W + CNT_W + 1;
  localparam int THR_W     = PROD_W - FRAC_BITS;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic REQ_COUNT  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]    count;
    logic                written;
  } slot_t;

  typedef struct packed {
    logic                count_en;
    logic                shift_en;
    logic                any_match;
    logic                any_free;
    logic [KEY_BITS-1:0] key;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_THR,
    ST_SEND
  } state_t;

endpackage

@@ rtl/core/fict_if.sv @@
// ----------------------------------------------------------------------------
// fict_req_if / fict_rpt_if
// Valid/ready channels for requests and slot reports.
// ----------------------------------------------------------------------------
interface fict_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] item_key;

  modport source (output valid, output req_type, output item_key, input ready);
  modport sink   (input valid, input req_type, input item_key, output ready);
endinterface

interface fict_rpt_if;
  logic        valid;
  logic        ready;
  logic [31:0] slot_key;
  logic [31:0] slot_count;
  logic        is_heavy;
  logic        is_last;

  modport source (output valid, output slot_key, output slot_count, output is_heavy,
                  output is_last, input ready);
  modport sink   (input valid, input slot_key, input slot_count, input is_heavy,
                  input is_last, output ready);
endinterface

@@ rtl/core/fict_cell.sv @@
// ----------------------------------------------------------------------------
// fict_cell
// One key/count slot: match and free priority chains, count update, and
// rotation toward the lower neighbor during a report.
// ----------------------------------------------------------------------------
module fict_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  fict_pkg::cell_ctrl_t ctrl,
  input  fict_pkg::slot_t      nbr,
  input  logic                 match_in,
  input  logic                 free_in,
  output fict_pkg::slot_t      slot,
  output logic                 match_out,
  output logic                 free_out
);

  fict_pkg::slot_t slot_next;
  logic            hit;
  logic            is_free;

  always_comb begin
    hit       = slot.written && (slot.key == ctrl.key);
    is_free   = (slot.count == '0);
    match_out = match_in | hit;
    free_out  = free_in | is_free;
    slot_next = slot;
    if (ctrl.shift_en) begin
      slot_next = nbr;
    end else if (ctrl.count_en) begin
      if (hit && !match_in) begin
        if (slot.count != fict_pkg::CNT_MAX) begin
          slot_next.count = slot.count + 1'b1;
        end
      end else if (!ctrl.any_match) begin
        if (is_free && !free_in) begin
          slot_next.key     = ctrl.key;
          slot_next.count   = fict_pkg::CNT_W'(1);
          slot_next.written = 1'b1;
        end else if (!ctrl.any_free && !is_free) begin
          slot_next.count = slot.count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

@@ rtl/core/fict_thresh.sv @@
// ----------------------------------------------------------------------------
// fict_thresh
// Heavy threshold: fraction times arrivals, then divide by 2^16 toward zero.
// Two register stages.
// ----------------------------------------------------------------------------
module fict_thresh (
  input  logic                                    clk,
  input  logic signed [fict_pkg::FRAC_W-1:0]      frac,
  input  logic        [fict_pkg::CNT_W-1:0]       arrivals,
  output logic signed [fict_pkg::THR_W-1:0]       thr
);

  localparam int PW = fict_pkg::PROD_W;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased;
  logic signed [fict_pkg::CNT_W:0] arr_s;

  always_comb begin
    arr_s  = $signed({1'b0, arrivals});
    biased = prod + (prod[PW-1] ? PW'((2 ** fict_pkg::FRAC_BITS) - 1) : PW'(0));
  end

  always_ff @(posedge clk) begin
    prod <= PW'(frac) * PW'(arr_s);
    thr  <= biased[PW-1:fict_pkg::FRAC_BITS];
  end

endmodule

@@ rtl/core/frequent_items_counter_table_top.sv @@
// ----------------------------------------------------------------------------
// frequent_items_counter_table_top
// Misra-Gries frequent-items table built as a ring of slot cells.
//
//   channel  dir  payload                                   transfer
//   req      in   req_type, item_key                        valid & ready
//   rpt      out  slot_key, slot_count, is_heavy, is_last   valid & ready
//   cfg      in   cfg_wr_data (threshold fraction, signed Q2.16) cfg_wr_en
//
// A count request updates the ring when it is accepted; a new request may follow next cycle.
// A report steps ST_MUL, ST_THR for the threshold multiply and divide, then one
// slot per cycle as the ring rotates through all NUM_SLOTS cells, back home.
// rpt stalls hold the ring; req is not ready from report accept to last load.
// rst is synchronous and clears all slots, the arrival total and the fraction.
// ----------------------------------------------------------------------------
module frequent_items_counter_table_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [fict_pkg::FRAC_W-1:0]         cfg_wr_data,
  fict_req_if.sink                            req,
  fict_rpt_if.source                          rpt
);

  localparam int N = fict_pkg::NUM_SLOTS;

  fict_pkg::state_t   state;
  fict_pkg::state_t   state_next;
  fict_pkg::cell_ctrl_t ctrl;
  fict_pkg::slot_t    slots [N];
  logic               match_c [N];
  logic               free_c [N];

  logic signed [fict_pkg::FRAC_W-1:0] frac;
  logic        [fict_pkg::CNT_W-1:0]  arrivals;
  logic signed [fict_pkg::THR_W-1:0]  thr;
  logic        [fict_pkg::SLOT_IW-1:0] idx;
  logic        [fict_pkg::SLOT_IW-1:0] idx_next;

  logic                          out_valid;
  logic                          out_valid_next;
  logic [fict_pkg::OUT_KEY_W-1:0] out_key;
  logic [fict_pkg::CNT_W-1:0]    out_count;
  logic                          out_heavy;
  logic                          out_last;

  logic req_fire;
  logic item_fire;
  logic load;
  logic at_last;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      fict_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .nbr       (slots[(g + 1) % N]),
        .match_in  ((g == 0) ? 1'b0 : match_c[(g + N - 1) % N]),
        .free_in   ((g == N - 1) ? 1'b0 : free_c[(g + 1) % N]),
        .slot      (slots[g]),
        .match_out (match_c[g]),
        .free_out  (free_c[g])
      );
    end
  endgenerate

  fict_thresh u_thresh (
    .clk      (clk),
    .frac     (frac),
    .arrivals (arrivals),
    .thr      (thr)
  );

  always_comb begin
    req.ready = (state == fict_pkg::ST_IDLE);
    req_fire  = req.valid && req.ready;
    item_fire = req_fire && (req.req_type == fict_pkg::REQ_COUNT);
    at_last   = (idx == fict_pkg::SLOT_IW'(N - 1));
    load      = (state == fict_pkg::ST_SEND) && (!out_valid || rpt.ready);

    ctrl.count_en  = item_fire;
    ctrl.shift_en  = load;
    ctrl.any_match = match_c[N - 1];
    ctrl.any_free  = free_c[0];
    ctrl.key       = fict_pkg::KEY_BITS'(req.item_key);

    state_next = state;
    idx_next   = idx;
    case (state)
      fict_pkg::ST_IDLE: begin
        if (req_fire && (req.req_type == fict_pkg::REQ_REPORT)) begin
          state_next = fict_pkg::ST_MUL;
        end
      end
      fict_pkg::ST_MUL: state_next = fict_pkg::ST_THR;
      fict_pkg::ST_THR: begin
        state_next = fict_pkg::ST_SEND;
        idx_next   = '0;
      end
      fict_pkg::ST_SEND: begin
        if (load) begin
          idx_next = idx + 1'b1;
          if (at_last) begin
            state_next = fict_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = fict_pkg::ST_IDLE;
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (rpt.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    rpt.valid      = out_valid;
    rpt.slot_key   = out_key;
    rpt.slot_count = out_count;
    rpt.is_heavy   = out_heavy;
    rpt.is_last    = out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fict_pkg::ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      arrivals  <= '0;
      frac      <= '0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
      if (item_fire && (arrivals != fict_pkg::CNT_MAX)) begin
        arrivals <= arrivals + 1'b1;
      end
      if (cfg_wr_en) begin
        frac <= $signed(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key   <= fict_pkg::OUT_KEY_W'(slots[0].key);
      out_count <= slots[0].count;
      out_heavy <= $signed({{(fict_pkg::THR_W - fict_pkg::CNT_W){1'b0}}, slots[0].count})
                   >= thr;
      out_last  <= at_last;
    end
  end

endmodule

@@ bench/frequent_items_counter_table_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequent_items_counter_table_top_tb
// Drives count and report requests into the frequent-items table through the
// valid/ready channels and checks every streamed slot against a local model of
// the table, under several threshold fractions and backpressure patterns.
// ----------------------------------------------------------------------------
module frequent_items_counter_table_top_tb;

  localparam int IDLE_GAP  = 8;
  localparam int END_GAP   = 20;
  localparam int LONG_HOLD = 300;
  localparam int HOT_KEYS  = 4;
  localparam int POOL_KEYS = 20;
  localparam int DIR_ROWS  = 25;

  typedef struct packed {
    logic [fict_pkg::OUT_KEY_W-1:0] key;
    logic [fict_pkg::CNT_W-1:0]     count;
    logic                           heavy;
    logic                           last;
  } slot_rpt_t;

  typedef struct packed {
    logic                          set_frac;
    logic [fict_pkg::FRAC_W-1:0]   frac;
    logic                          req_type;
    logic [fict_pkg::IN_KEY_W-1:0] key;
    logic                          empty_tbl;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [fict_pkg::FRAC_W-1:0]   cfg_wr_data;

  fict_req_if req_ch ();
  fict_rpt_if rpt_ch ();

  frequent_items_counter_table_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rpt         (rpt_ch)
  );

  logic [fict_pkg::KEY_BITS-1:0]      tbl_keys    [fict_pkg::NUM_SLOTS];
  logic [fict_pkg::CNT_W-1:0]         tbl_counts  [fict_pkg::NUM_SLOTS];
  logic                               tbl_written [fict_pkg::NUM_SLOTS];
  logic [fict_pkg::CNT_W-1:0]         arrivals;
  logic signed [fict_pkg::FRAC_W-1:0] frac_q16;
  slot_rpt_t                          pending_slots [$];
  slot_rpt_t                          want_slot;
  logic [fict_pkg::IN_KEY_W-1:0]      key_pool [POOL_KEYS];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 18'sd0,       fict_pkg::REQ_REPORT, 32'h0000_0000, 1'b1},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0000_0000, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hFFFF_FFFF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0000_0000, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0000_0001, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h8000_0000, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h5555_5555, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hAAAA_AAAA, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0000_FFFF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hFFFF_0000, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h1234_5678, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h8765_4321, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0000_0002, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h7FFF_FFFF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hFFFF_FFFE, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hDEAD_BEEF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'h0F0F_0F0F, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hF0F0_F0F0, 1'b0},
    '{1'b1, 18'sd65536,   fict_pkg::REQ_REPORT, 32'h0000_0000, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hCAFE_F00D, 1'b0},
    '{1'b1, -18'sd65536,  fict_pkg::REQ_REPORT, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hFFFF_FFFF, 1'b0},
    '{1'b0, 18'sd0,       fict_pkg::REQ_COUNT,  32'hCAFE_F00D, 1'b0},
    '{1'b1, 18'sd131071,  fict_pkg::REQ_REPORT, 32'h0000_0000, 1'b0},
    '{1'b1, -18'sd131072, fict_pkg::REQ_REPORT, 32'h0000_0000, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // count one arrival into the table
  function automatic void count_arrival(input logic [fict_pkg::IN_KEY_W-1:0] item);
    int hit;
    int free_slot;
    logic [fict_pkg::KEY_BITS-1:0] k;
    hit = -1;
    free_slot = -1;
    k = item[fict_pkg::KEY_BITS-1:0];
    if (arrivals != fict_pkg::CNT_MAX) arrivals++;
    for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
      if (hit < 0 && tbl_written[i] && tbl_keys[i] == k) hit = i;
    end
    if (hit >= 0) begin
      if (tbl_counts[hit] != fict_pkg::CNT_MAX) tbl_counts[hit]++;
      return;
    end
    for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
      if (tbl_counts[i] == '0) free_slot = i;
    end
    if (free_slot >= 0) begin
      tbl_keys[free_slot]    = k;
      tbl_counts[free_slot]  = fict_pkg::CNT_W'(1);
      tbl_written[free_slot] = 1'b1;
    end else begin
      for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
        if (tbl_counts[i] != '0) tbl_counts[i]--;
      end
    end
  endfunction

  function automatic void queue_report();
    longint    thr;
    slot_rpt_t r;
    thr = (longint'(frac_q16) * longint'(arrivals)) / 65536;
    for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
      r.key   = fict_pkg::OUT_KEY_W'(tbl_keys[i]);
      r.count = tbl_counts[i];
      r.heavy = longint'(tbl_counts[i]) >= thr;
      r.last  = (i == fict_pkg::NUM_SLOTS - 1);
      pending_slots.push_back(r);
    end
  endfunction

  task automatic send_req(input logic rt, input logic [fict_pkg::IN_KEY_W-1:0] k,
                          input bit empty_tbl);
    slot_rpt_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = rt;
    req_ch.item_key = k;
    do @(posedge clk); while (!req_ch.ready);
    if (rt == fict_pkg::REQ_COUNT) begin
      count_arrival(k);
    end else if (empty_tbl) begin
      for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
        r = '{key: '0, count: '0, heavy: 1'b1, last: (i == fict_pkg::NUM_SLOTS - 1)};
        pending_slots.push_back(r);
      end
    end else begin
      queue_report();
    end
    @(negedge clk);
  endtask

  task automatic settle_idle();
    req_ch.valid = 1'b0;
    while (pending_slots.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_frac(input logic [fict_pkg::FRAC_W-1:0] v);
    settle_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    frac_q16    = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // mostly a skewed key pool so slots survive, with some fully random keys and some reports
  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      send_req(fict_pkg::REQ_REPORT, $urandom, 1'b0);
    else if (pick < 50)
      send_req(fict_pkg::REQ_COUNT, key_pool[$urandom_range(0, HOT_KEYS - 1)], 1'b0);
    else if (pick < 80)
      send_req(fict_pkg::REQ_COUNT, key_pool[$urandom_range(0, POOL_KEYS - 1)], 1'b0);
    else
      send_req(fict_pkg::REQ_COUNT, $urandom, 1'b0);
  endtask

  task automatic run_phase(input logic [fict_pkg::FRAC_W-1:0] frac, input int idle_pct,
                           input int stall_pct, input int n, input bit pressure);
    write_frac(frac);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (pressure) begin
      send_req(fict_pkg::REQ_REPORT, '0, 1'b0);
      hold_pending = 1'b1;
      n--;
    end
    repeat (n) send_random();
  endtask

  // result side ready: random stalls, or one long hold-off on request
  initial begin
    rpt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rpt_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        rpt_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rpt_ch.valid && rpt_ch.ready) begin
      if (pending_slots.size() == 0) begin
        $error("unexpected slot transfer: slot_key %h slot_count %h",
               rpt_ch.slot_key, rpt_ch.slot_count);
        mismatch_count++;
      end else begin
        want_slot = pending_slots.pop_front();
        if (rpt_ch.slot_key !== want_slot.key) begin
          $error("slot_key: expected %h, actual %h", want_slot.key, rpt_ch.slot_key);
          mismatch_count++;
        end
        if (rpt_ch.slot_count !== want_slot.count) begin
          $error("slot_count: expected %h, actual %h", want_slot.count, rpt_ch.slot_count);
          mismatch_count++;
        end
        if (rpt_ch.is_heavy !== want_slot.heavy) begin
          $error("is_heavy: expected %b, actual %b", want_slot.heavy, rpt_ch.is_heavy);
          mismatch_count++;
        end
        if (rpt_ch.is_last !== want_slot.last) begin
          $error("is_last: expected %b, actual %b", want_slot.last, rpt_ch.is_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = fict_pkg::REQ_COUNT;
    req_ch.item_key = '0;
    for (int i = 0; i < fict_pkg::NUM_SLOTS; i++) begin
      tbl_keys[i]    = '0;
      tbl_counts[i]  = '0;
      tbl_written[i] = 1'b0;
    end
    arrivals = '0;
    frac_q16 = '0;
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = $urandom;
    key_pool[HOT_KEYS]     = '0;
    key_pool[HOT_KEYS + 1] = '1;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.set_frac) write_frac(row.frac);
      send_req(row.req_type, row.key, row.empty_tbl);
    end

    run_phase(18'sd32768,    0,  0, 50, 1'b0);
    run_phase(18'sd6554,     47, 0, 50, 1'b0);
    run_phase(-18'sd3277,    0, 47, 50, 1'b0);
    run_phase(18'sd13107,    6,  6, 50, 1'b0);
    run_phase(fict_pkg::FRAC_W'($urandom), 0, 0, 50, 1'b1);
    run_phase(18'sd1000,     47, 47, 35, 1'b0);

    req_ch.valid = 1'b0;
    while (pending_slots.size() != 0) @(negedge clk);
    repeat (END_GAP) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fict_pkg.sv
rtl/core/fict_if.sv
rtl/core/fict_cell.sv
rtl/core/fict_thresh.sv
rtl/core/frequent_items_counter_table_top.sv
bench/frequent_items_counter_table_top_tb.sv
